/* rtl/mase_pkg.sv */
// Package: shared constants for the multicycle ALU station execute core.
`default_nettype none

package mase_pkg;

    // Field widths
    localparam int DataWidth    = 16;
    localparam int LatWidth     = 6;
    localparam int NumStations  = 8;
    localparam int StationWidth = $clog2(NumStations);
    localparam int OpWidth      = 3;
    localparam int NumRegs      = 6;
    localparam int RegIdxWidth  = $clog2(NumRegs);

    // Packed request layout (lowest bit first)
    localparam int InPackWidth  = StationWidth + 5 * DataWidth;
    localparam int InDataWidth  = ((InPackWidth + 7) / 8) * 8;
    localparam int OutUserWidth = 5;

    // Opcodes
    localparam logic [OpWidth-1:0] OP_ADD  = 3'd0;
    localparam logic [OpWidth-1:0] OP_ADDI = 3'd1;
    localparam logic [OpWidth-1:0] OP_DIV  = 3'd2;
    localparam logic [OpWidth-1:0] OP_BEQ  = 3'd3;
    localparam logic [OpWidth-1:0] OP_JAL  = 3'd4;
    localparam logic [OpWidth-1:0] OP_JALR = 3'd5;
    localparam logic [OpWidth-1:0] OP_NEG  = 3'd6;
    localparam logic [OpWidth-1:0] OP_ABS  = 3'd7;

    // Latency register indexes
    localparam logic [RegIdxWidth-1:0] REG_ADD_LAT    = 3'd0;
    localparam logic [RegIdxWidth-1:0] REG_DIV_LAT    = 3'd1;
    localparam logic [RegIdxWidth-1:0] REG_BRANCH_LAT = 3'd2;
    localparam logic [RegIdxWidth-1:0] REG_JUMP_LAT   = 3'd3;
    localparam logic [RegIdxWidth-1:0] REG_NEG_LAT    = 3'd4;
    localparam logic [RegIdxWidth-1:0] REG_ABS_LAT    = 3'd5;

    typedef logic [DataWidth-1:0] t_data;
    typedef logic [LatWidth-1:0]  t_lat;

    // Completion flags of one result
    typedef struct packed {
        logic jump_resolved;
        logic branch_resolved;
        logic branch_taken;
        logic result_written;
        logic finished;
    } t_flags;

endpackage

`default_nettype wire

/* rtl/multicycle_alu_station_exec_core.sv */
// Top level: reservation station execute core with per-station cycle counters.
`default_nettype none

// Each request is one cycle of one busy reservation station. The per-station
// cycle counters live in an 8-entry synchronous memory (registered read) with
// a valid bit per entry, so all counters read as zero right after reset with
// no clearing pass. A request is read from the counter memory on acceptance,
// evaluated and written back in the next cycle (S_EVAL), and the result is
// handed to the output register in S_PUSH; s_axis_tready rises again only
// when the sequencer is back in S_IDLE after that hand-off.
// A finishing signed divide by a nonzero divisor runs a radix-2 restoring
// divider, one quotient bit a cycle (16 steps in S_DIV plus a sign-fix
// step in S_DFIX) between S_EVAL and S_PUSH. The hand-off to the
// output register waits while that register still holds an unaccepted result.
// The core takes one request at a time; a new request may be accepted while
// the previous result still waits at the output. Latency registers are
// written through the configuration channel, which is always ready.
module multicycle_alu_station_exec_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [mase_pkg::RegIdxWidth-1:0]    i_cfg_index,
    input  wire logic [mase_pkg::LatWidth-1:0]       i_cfg_data,
    // Station request stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // tdata: station[2:0], operand_j[18:3], operand_k[34:19], immediate[50:35],
    //        instruction_pc[66:51], fetch_pc[82:67], zero pad[87:83]
    input  wire logic [mase_pkg::InDataWidth-1:0]    s_axis_tdata,
    // tuser: opcode[2:0]
    input  wire logic [mase_pkg::OpWidth-1:0]        s_axis_tuser,
    // Result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // tdata: result_value[15:0]
    output logic [mase_pkg::DataWidth-1:0]           m_axis_tdata,
    // tuser: finished[0], result_written[1], branch_taken[2],
    //        branch_resolved[3], jump_resolved[4]
    output logic [mase_pkg::OutUserWidth-1:0]        m_axis_tuser
);

    localparam int DW = mase_pkg::DataWidth;
    localparam int SW = mase_pkg::StationWidth;
    localparam int DivCntWidth = $clog2(DW);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_DFIX = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0] r_state, n_state;

    // Latency registers
    mase_pkg::t_lat r_lat [mase_pkg::NumRegs];

    // Counter memory and its valid bits
    mase_pkg::t_lat r_cnt_mem [mase_pkg::NumStations];
    logic [mase_pkg::NumStations-1:0] r_cnt_vld;
    mase_pkg::t_lat r_cnt_rd;
    logic           r_vld_rd;

    // Latched request
    logic [SW-1:0]               r_station;
    logic [mase_pkg::OpWidth-1:0] r_op;
    mase_pkg::t_data r_vj, r_vk, r_imm, r_ipc, r_fpc;

    // Divider
    mase_pkg::t_data        r_quo, r_dvs, r_rem;
    logic                   r_neg;
    logic [DivCntWidth-1:0] r_div_cnt;

    // Pending result
    mase_pkg::t_data  r_res_value;
    mase_pkg::t_flags r_res_flags;

    // Output register
    logic             r_m_valid;
    mase_pkg::t_data  r_m_data;
    mase_pkg::t_flags r_m_flags;

    logic in_fire, cfg_fire, out_free;
    mase_pkg::t_lat  cnt_cur, cnt_next, lat_sel;
    logic            done;
    logic            div_go;
    mase_pkg::t_data eval_value;
    mase_pkg::t_flags eval_flags;
    logic [DW:0]     div_shift, div_trial;

    assign o_cfg_ready   = 1'b1;
    assign cfg_fire      = i_cfg_valid;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_flags;

    // Latency of the current opcode
    always_comb begin
        case (r_op)
            mase_pkg::OP_ADD, mase_pkg::OP_ADDI: lat_sel = r_lat[mase_pkg::REG_ADD_LAT];
            mase_pkg::OP_DIV:                    lat_sel = r_lat[mase_pkg::REG_DIV_LAT];
            mase_pkg::OP_BEQ:                    lat_sel = r_lat[mase_pkg::REG_BRANCH_LAT];
            mase_pkg::OP_JAL, mase_pkg::OP_JALR: lat_sel = r_lat[mase_pkg::REG_JUMP_LAT];
            mase_pkg::OP_NEG:                    lat_sel = r_lat[mase_pkg::REG_NEG_LAT];
            default:                             lat_sel = r_lat[mase_pkg::REG_ABS_LAT];
        endcase
    end

    // Counter update; wraps at six bits
    assign cnt_cur  = r_vld_rd ? r_cnt_rd : '0;
    assign cnt_next = cnt_cur + mase_pkg::LatWidth'(1);
    assign done     = !(cnt_next < lat_sel);
    assign div_go   = done && (r_op == mase_pkg::OP_DIV) && (r_vk != '0);

    // Result value and flags of a finishing operation (the divider overwrites the value for a nonzero divisor)
    always_comb begin
        eval_value = '0;
        eval_flags = '0;
        if (done) begin
            eval_flags.finished       = 1'b1;
            eval_flags.result_written = 1'b1;
            case (r_op)
                mase_pkg::OP_ADD:  eval_value = r_vj + r_vk;
                mase_pkg::OP_ADDI: eval_value = r_vj + r_imm;
                mase_pkg::OP_DIV:  eval_value = '1;   // divide by zero
                mase_pkg::OP_BEQ: begin
                    eval_flags.branch_resolved = 1'b1;
                    if (r_vj == r_vk) begin
                        eval_flags.branch_taken = 1'b1;
                        eval_value = r_ipc + r_imm + DW'(1);
                    end else begin
                        eval_flags.result_written = 1'b0;
                    end
                end
                mase_pkg::OP_JAL: begin
                    eval_value = r_fpc + r_imm + DW'(1);
                    eval_flags.jump_resolved = 1'b1;
                end
                mase_pkg::OP_JALR: begin
                    eval_value = r_vj;
                    eval_flags.jump_resolved = 1'b1;
                end
                mase_pkg::OP_NEG: eval_value = -r_vj;
                mase_pkg::OP_ABS: eval_value = r_vj[DW-1] ? -r_vj : r_vj;
                default:          eval_value = '0;
            endcase
        end
    end

    // Restoring divide step on magnitudes
    assign div_shift = {r_rem, r_quo[DW-1]};
    assign div_trial = div_shift - {1'b0, r_dvs};

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_fire) n_state = S_EVAL;
            S_EVAL: n_state = div_go ? S_DIV : S_PUSH;
            S_DIV:  if (r_div_cnt == DivCntWidth'(DW - 1)) n_state = S_DFIX;
            S_DFIX: n_state = S_PUSH;
            S_PUSH: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_cnt_vld <= '0;
            r_div_cnt <= '0;
            r_lat[mase_pkg::REG_ADD_LAT]    <= mase_pkg::LatWidth'(1);
            r_lat[mase_pkg::REG_DIV_LAT]    <= mase_pkg::LatWidth'(8);
            r_lat[mase_pkg::REG_BRANCH_LAT] <= mase_pkg::LatWidth'(1);
            r_lat[mase_pkg::REG_JUMP_LAT]   <= mase_pkg::LatWidth'(1);
            r_lat[mase_pkg::REG_NEG_LAT]    <= mase_pkg::LatWidth'(1);
            r_lat[mase_pkg::REG_ABS_LAT]    <= mase_pkg::LatWidth'(1);
        end else begin
            r_state <= n_state;
            if (cfg_fire && (i_cfg_index < mase_pkg::RegIdxWidth'(mase_pkg::NumRegs))) begin
                r_lat[i_cfg_index] <= i_cfg_data;
            end
            if (r_state == S_EVAL) begin
                r_cnt_vld[r_station] <= 1'b1;
            end
            if (r_state == S_EVAL) begin
                r_div_cnt <= '0;
            end else if (r_state == S_DIV) begin
                r_div_cnt <= r_div_cnt + DivCntWidth'(1);
            end
            if (r_state == S_PUSH && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Counter memory: read on acceptance, write back after evaluation
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cnt_rd <= r_cnt_mem[s_axis_tdata[SW-1:0]];
            r_vld_rd <= r_cnt_vld[s_axis_tdata[SW-1:0]];
        end
        if (r_state == S_EVAL) begin
            r_cnt_mem[r_station] <= done ? '0 : cnt_next;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_station <= s_axis_tdata[SW-1:0];
            r_vj      <= s_axis_tdata[SW +: DW];
            r_vk      <= s_axis_tdata[SW + DW +: DW];
            r_imm     <= s_axis_tdata[SW + 2*DW +: DW];
            r_ipc     <= s_axis_tdata[SW + 3*DW +: DW];
            r_fpc     <= s_axis_tdata[SW + 4*DW +: DW];
            r_op      <= s_axis_tuser;
        end
        case (r_state)
            S_EVAL: begin
                r_res_value <= eval_value;
                r_res_flags <= eval_flags;
                r_quo <= r_vj[DW-1] ? -r_vj : r_vj;
                r_dvs <= r_vk[DW-1] ? -r_vk : r_vk;
                r_rem <= '0;
                r_neg <= r_vj[DW-1] ^ r_vk[DW-1];
            end
            S_DIV: begin
                if (!div_trial[DW]) begin
                    r_rem <= div_trial[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], 1'b1};
                end else begin
                    r_rem <= div_shift[DW-1:0];
                    r_quo <= {r_quo[DW-2:0], 1'b0};
                end
            end
            S_DFIX: begin
                r_res_value <= r_neg ? -r_quo : r_quo;
            end
            default: begin
            end
        endcase
        if (r_state == S_PUSH && out_free) begin
            r_m_data  <= r_res_value;
            r_m_flags <= r_res_flags;
        end
    end

endmodule

`default_nettype wire
